// ===== sv/lppd_pkg.sv =====
// ----------------------------------------------------------------------------
// lppd_pkg: shared types and constants of the packet deframer
// Result kinds, the result record and the header and length constants.
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam int unsigned LEN_W = 20;

  // Header: length, sequence number and protocol id, four bytes each
  localparam logic [LEN_W-1:0] HDR_BYTES = 20'd12;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 20'd8192;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD_LEN = 2'd2,
    KIND_STALE   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [31:0] protocol_id;
    logic [31:0] sequence_number;
    logic        first_of_message;
    logic        last_of_message;
  } res_t;

endpackage

// ===== sv/lppd_ifs.sv =====
// ----------------------------------------------------------------------------
// lppd_ifs: valid/ready channels of the packet deframer
// Byte stream in, result stream out and the max length write channel.
// ----------------------------------------------------------------------------
interface lppd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lppd_result_if
  import lppd_pkg::*;
;
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  payload_byte;
  logic [31:0] protocol_id;
  logic [31:0] sequence_number;
  logic        first_of_message;
  logic        last_of_message;

  modport source (output valid, output kind, output payload_byte, output protocol_id,
                  output sequence_number, output first_of_message,
                  output last_of_message, input ready);
  modport sink   (input valid, input kind, input payload_byte, input protocol_id,
                  input sequence_number, input first_of_message,
                  input last_of_message, output ready);
endinterface

interface lppd_cfg_if
  import lppd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] max_packet_length;

  modport source (output valid, output max_packet_length, input ready);
  modport sink   (input valid, input max_packet_length, output ready);
endinterface

// ===== sv/lppd_parser.sv =====
// ----------------------------------------------------------------------------
// lppd_parser: header assembly, length and sequence checks, payload tagging
// Updates the framing state once per accepted byte and forms its result.
// ----------------------------------------------------------------------------
module lppd_parser
  import lppd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [7:0]       byte_i,
  input  logic [LEN_W-1:0] max_len_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  logic [LEN_W-1:0] pos_q, pos_d;
  logic [31:0]      len_q, len_d;
  logic [31:0]      seq_q, seq_d;
  logic [31:0]      proto_q, proto_d;
  logic [31:0]      last_seq_q, last_seq_d;
  logic             skip_q, skip_d;

  logic [31:0]      len_shift, seq_shift, proto_shift;
  logic [LEN_W-1:0] pos_inc;
  logic [LEN_W:0]   pos_plus1;
  logic             bad_len, is_last, is_first;

  // Place a byte into its lane; lane zero starts a fresh word
  function automatic logic [31:0] shift_in(logic [31:0] w, logic [7:0] b,
                                           logic [1:0] lane);
    logic [31:0] r;
    r = w;
    case (lane)
      2'd0:    r = {24'd0, b};
      2'd1:    r = {w[31:16], b, w[7:0]};
      2'd2:    r = {w[31:24], b, w[15:0]};
      default: r = {b, w[23:0]};
    endcase
    return r;
  endfunction

  assign len_shift   = shift_in(len_q, byte_i, pos_q[1:0]);
  assign seq_shift   = shift_in(seq_q, byte_i, pos_q[1:0]);
  assign proto_shift = shift_in(proto_q, byte_i, pos_q[1:0]);
  assign pos_inc     = pos_q + 20'd1;
  assign pos_plus1   = {1'b0, pos_q} + 21'd1;
  assign bad_len     = (len_shift < {12'd0, HDR_BYTES}) || (len_shift > {12'd0, max_len_i});
  assign is_last     = {11'd0, pos_plus1} >= len_q;
  assign is_first    = pos_q == HDR_BYTES;

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    seq_d       = seq_q;
    proto_d     = proto_q;
    last_seq_d  = last_seq_q;
    skip_d      = skip_q;
    res_valid_o = 1'b0;
    res_o.kind             = KIND_PAYLOAD;
    res_o.payload_byte     = 8'd0;
    res_o.protocol_id      = 32'd0;
    res_o.sequence_number  = 32'd0;
    res_o.first_of_message = 1'b1;
    res_o.last_of_message  = 1'b1;
    if (acc_i) begin
      if (pos_q < 20'd4) begin
        len_d = len_shift;
        if (pos_q == 20'd3 && bad_len) begin
          // drop the header and resync on the next byte
          pos_d       = '0;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BAD_LEN;
        end else begin
          pos_d = pos_inc;
        end
      end else if (pos_q < 20'd8) begin
        seq_d = seq_shift;
        pos_d = pos_inc;
      end else if (pos_q < HDR_BYTES) begin
        proto_d = proto_shift;
        if (pos_q != HDR_BYTES - 20'd1) begin
          pos_d = pos_inc;
        end else if (seq_q <= last_seq_q) begin
          // stale: report, then swallow any payload
          res_valid_o           = 1'b1;
          res_o.kind            = KIND_STALE;
          res_o.protocol_id     = proto_shift;
          res_o.sequence_number = seq_q;
          if (len_q == {12'd0, HDR_BYTES}) begin
            pos_d  = '0;
            skip_d = 1'b0;
          end else begin
            pos_d  = HDR_BYTES;
            skip_d = 1'b1;
          end
        end else begin
          last_seq_d = seq_q;
          skip_d     = 1'b0;
          if (len_q == {12'd0, HDR_BYTES}) begin
            pos_d                 = '0;
            res_valid_o           = 1'b1;
            res_o.kind            = KIND_EMPTY;
            res_o.protocol_id     = proto_shift;
            res_o.sequence_number = seq_q;
          end else begin
            pos_d = HDR_BYTES;
          end
        end
      end else begin
        if (is_last) begin
          pos_d  = '0;
          skip_d = 1'b0;
        end else begin
          pos_d = pos_inc;
        end
        res_valid_o            = !skip_q;
        res_o.kind             = KIND_PAYLOAD;
        res_o.payload_byte     = byte_i;
        res_o.protocol_id      = proto_q;
        res_o.sequence_number  = seq_q;
        res_o.first_of_message = is_first;
        res_o.last_of_message  = is_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      len_q      <= '0;
      seq_q      <= '0;
      proto_q    <= '0;
      last_seq_q <= '0;
      skip_q     <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      len_q      <= len_d;
      seq_q      <= seq_d;
      proto_q    <= proto_d;
      last_seq_q <= last_seq_d;
      skip_q     <= skip_d;
    end
  end

  a_skip_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> pos_q >= HDR_BYTES)
    else $error("payload skip set outside the payload region");

  a_bad_len_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_BAD_LEN) |=> pos_q == '0)
    else $error("no resync after a bad length");

  a_last_seq_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_seq_q != $past(last_seq_q)) |-> (last_seq_q > $past(last_seq_q)))
    else $error("last accepted sequence number went backward");

endmodule

// ===== sv/lppd_out_buf.sv =====
// ----------------------------------------------------------------------------
// lppd_out_buf: two-entry result buffer
// Decouples the parser from a stalling receiver at full byte rate.
// ----------------------------------------------------------------------------
module lppd_out_buf
  import lppd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic room_o,
  lppd_result_if.source res_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop    = res_o.valid && res_o.ready;
  assign room_o = cnt_q != 2'd2;

  assign res_o.valid            = cnt_q != 2'd0;
  assign res_o.kind             = mem_q[rd_ptr_q].kind;
  assign res_o.payload_byte     = mem_q[rd_ptr_q].payload_byte;
  assign res_o.protocol_id      = mem_q[rd_ptr_q].protocol_id;
  assign res_o.sequence_number  = mem_q[rd_ptr_q].sequence_number;
  assign res_o.first_of_message = mem_q[rd_ptr_q].first_of_message;
  assign res_o.last_of_message  = mem_q[rd_ptr_q].last_of_message;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && cnt_q == 2'd2))
    else $error("result pushed into a full buffer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result buffer count out of range");

endmodule

// ===== sv/length_prefixed_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer: length-prefixed packet deframer
// Splits a byte stream into packets and checks length and sequence number.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one received byte per transaction. Every packet opens with
//   a 12-byte little-endian header: total length, sequence number, protocol
//   id. res_o carries at most one result per byte: a tagged payload byte, an
//   empty-message mark for a header-only packet, a bad-length drop (resync
//   on the next byte) or a stale-sequence drop (payload then swallowed).
//   cfg_i writes max_packet_length; write it only while the block is idle.
// Timing:
//   One byte per cycle sustained while the result buffer has room. Each
//   result is registered into the result buffer as its byte is accepted.
// Reset:
//   Framing state clears to the start of a header, the last accepted
//   sequence number to zero, max_packet_length to 8192.
// Back-pressure:
//   A two-entry result buffer absorbs a stall on res_o; rx_i.ready drops
//   only when both entries hold results not yet taken.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer
  import lppd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lppd_byte_if.sink     rx_i,
  lppd_cfg_if.sink      cfg_i,
  lppd_result_if.source res_o
);

  logic [LEN_W-1:0] max_len_q;
  logic             room;
  logic             acc;
  logic             res_valid;
  res_t             res;

  // Config writes are always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_packet_length;
    end
  end

  // Hold input while the result buffer is full
  assign rx_i.ready = room;
  assign acc        = rx_i.valid && room;

  lppd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .byte_i      (rx_i.data_byte),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lppd_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .res_i  (res),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule
